[src/osam_pkg.sv]
// ----------------------------------------------------------------------------
// osam_pkg: shared types and constants for the switching activity monitor
// Field widths, status codes and state machine encodings used by all parts but the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package osam_pkg;

  localparam int ID_W    = 8;
  localparam int CNT_W   = 2;
  localparam int IN_W    = 32;
  localparam int SC_W    = 32;
  localparam int AVG_W   = 22;
  localparam int MAX_OPS = 3;

  typedef enum logic [1:0] {
    ST_CREATED  = 2'd0,
    ST_UPDATED  = 2'd1,
    ST_RANGE    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef enum logic {
    F_IDLE,
    F_RUN
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_HOLD
  } back_state_t;

  typedef struct packed {
    status_t               status;
    logic [SC_W-1:0]       sample_count;
    logic [CNT_W-1:0]      operand_count;
  } job_ctl_t;

endpackage

`default_nettype wire

[src/osam_ifs.sv]
// ----------------------------------------------------------------------------
// osam channel interfaces
// Event channel into the monitor and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface osam_evt_if;
  import osam_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ID_W-1:0]      operator_id;
  logic [CNT_W-1:0]     operand_count;
  logic [IN_W-1:0]      operand_a;
  logic [IN_W-1:0]      operand_b;
  logic [IN_W-1:0]      operand_c;

  modport source (output valid, operator_id, operand_count, operand_a, operand_b,
                  operand_c, input ready);
  modport sink (input valid, operator_id, operand_count, operand_a, operand_b,
                operand_c, output ready);
endinterface

interface osam_res_if;
  import osam_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [SC_W-1:0]      sample_count;
  logic [AVG_W-1:0]     average_distance_a;
  logic [AVG_W-1:0]     average_distance_b;
  logic [AVG_W-1:0]     average_distance_c;

  modport source (output valid, status, sample_count, average_distance_a,
                  average_distance_b, average_distance_c, input ready);
  modport sink (input valid, status, sample_count, average_distance_a,
                average_distance_b, average_distance_c, output ready);
endinterface

`default_nettype wire

[src/osam_front.sv]
// ----------------------------------------------------------------------------
// osam_front: event intake and table update
// Reads the operator entry, classifies the event, writes a created or updated
// entry back and queues the entry's sums and count for the averaging stage.
// ----------------------------------------------------------------------------
`default_nettype none

module osam_front #(
  parameter int OPERATOR_SLOTS = 256,
  parameter int OPERAND_WIDTH  = 32,
  parameter int SUM_W          = 38
) (
  input  logic                clk,
  input  logic                rst,
  osam_evt_if.sink            evt,
  output logic                push,
  output osam_pkg::job_ctl_t  push_ctl,
  output logic [SUM_W-1:0]    push_sums [osam_pkg::MAX_OPS],
  input  logic                full
);
  import osam_pkg::*;

  localparam int SW    = $clog2(OPERATOR_SLOTS);
  localparam int PC_W  = $clog2(OPERAND_WIDTH + 1);
  localparam int LW    = OPERAND_WIDTH + SUM_W;
  localparam int MW    = SC_W + CNT_W;
  localparam int IDS   = 2 ** ID_W;

  front_state_t state, state_next;

  logic [SW-1:0]   slot_lut [IDS];
  logic [SW-1:0]   rd_slot;
  logic [SW-1:0]   slot;
  logic [CNT_W-1:0] n;
  logic [OPERAND_WIDTH-1:0] ops [MAX_OPS];
  logic [OPERATOR_SLOTS-1:0] valid;

  logic [MW-1:0]   meta_mem [OPERATOR_SLOTS];
  logic [MW-1:0]   meta_rd;
  logic [LW-1:0]   lane_rd [MAX_OPS];

  logic            accept;
  logic            meta_we;
  logic [MW-1:0]   meta_wd;
  logic            lane_we  [MAX_OPS];
  logic [OPERAND_WIDTH-1:0] prev_new [MAX_OPS];
  logic [SUM_W-1:0] sum_new [MAX_OPS];

  logic [SC_W-1:0]  old_cnt;
  logic [CNT_W-1:0] old_n;
  logic             sat;

  function automatic logic [PC_W-1:0] popcnt(input logic [OPERAND_WIDTH-1:0] x);
    logic [PC_W-1:0] c;
    c = '0;
    for (int i = 0; i < OPERAND_WIDTH; i++) begin
      c = c + PC_W'(x[i]);
    end
    return c;
  endfunction

  // id folding onto the table, worked out at elaboration
  for (genvar g = 0; g < IDS; g++) begin : g_lut
    assign slot_lut[g] = SW'(g % OPERATOR_SLOTS);
  end

  assign evt.ready = (state == F_IDLE);
  assign accept    = evt.valid && evt.ready;
  assign rd_slot   = slot_lut[evt.operator_id];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    case (state)
      F_IDLE: begin
        if (accept) state_next = F_RUN;
      end
      F_RUN: begin
        if (!full) begin
          push       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot   <= rd_slot;
      n      <= evt.operand_count;
      ops[0] <= OPERAND_WIDTH'(evt.operand_a);
      ops[1] <= OPERAND_WIDTH'(evt.operand_b);
      ops[2] <= OPERAND_WIDTH'(evt.operand_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (push) begin
      valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && meta_we) meta_mem[slot] <= meta_wd;
    if (accept) meta_rd <= meta_mem[rd_slot];
  end

  for (genvar k = 0; k < MAX_OPS; k++) begin : g_lane
    logic [LW-1:0] mem [OPERATOR_SLOTS];
    always_ff @(posedge clk) begin
      if (push && lane_we[k]) mem[slot] <= {prev_new[k], sum_new[k]};
      if (accept) lane_rd[k] <= mem[rd_slot];
    end
  end

  assign old_cnt = meta_rd[MW-1:CNT_W];
  assign old_n   = meta_rd[CNT_W-1:0];
  assign sat     = (old_cnt == '1);

  always_comb begin
    meta_we  = 1'b0;
    meta_wd  = meta_rd;
    push_ctl = '{status: ST_RANGE, sample_count: old_cnt, operand_count: old_n};
    for (int k = 0; k < MAX_OPS; k++) begin
      lane_we[k]   = 1'b0;
      prev_new[k]  = lane_rd[k][LW-1:SUM_W];
      sum_new[k]   = lane_rd[k][SUM_W-1:0];
    end
    if (!valid[slot]) begin
      meta_we = 1'b1;
      for (int k = 0; k < MAX_OPS; k++) begin
        lane_we[k]  = 1'b1;
        sum_new[k]  = '0;
        prev_new[k] = (CNT_W'(k) < n) ? ops[k] : '0;
      end
      if (n == '0) begin
        push_ctl = '{status: ST_RANGE, sample_count: '0, operand_count: '0};
      end else begin
        push_ctl = '{status: ST_CREATED, sample_count: SC_W'(1), operand_count: n};
      end
      meta_wd = {push_ctl.sample_count, push_ctl.operand_count};
    end else if (n == '0) begin
      push_ctl.status = ST_RANGE;
    end else if (n != old_n) begin
      push_ctl.status = ST_MISMATCH;
    end else begin
      meta_we = 1'b1;
      push_ctl.status       = ST_UPDATED;
      push_ctl.sample_count = sat ? old_cnt : old_cnt + SC_W'(1);
      meta_wd = {push_ctl.sample_count, old_n};
      for (int k = 0; k < MAX_OPS; k++) begin
        if (CNT_W'(k) < n) begin
          lane_we[k]  = 1'b1;
          prev_new[k] = ops[k];
          // hold the sum once the count has saturated
          if (!sat) begin
            sum_new[k] = lane_rd[k][SUM_W-1:0]
                       + SUM_W'(popcnt(ops[k] ^ lane_rd[k][LW-1:SUM_W]));
          end
        end
      end
    end
    for (int k = 0; k < MAX_OPS; k++) begin
      push_sums[k] = sum_new[k];
    end
  end

endmodule

`default_nettype wire

[src/osam_fifo.sv]
// ----------------------------------------------------------------------------
// osam_fifo: two-entry job queue
// Decouples table update from averaging.
// ----------------------------------------------------------------------------
`default_nettype none

module osam_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] slots [2];
  logic         wp, rp;
  logic [1:0]   fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign rdata = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

[src/osam_back.sv]
// ----------------------------------------------------------------------------
// osam_back: averaging stage
// Three restoring dividers form sum * 2^F / (count - 1), then a result
// register holds the item for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module osam_back #(
  parameter int OPERAND_WIDTH = 32,
  parameter int FRACTION_BITS = 16,
  parameter int SUM_W         = 38
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  osam_pkg::job_ctl_t  job_ctl,
  input  logic [SUM_W-1:0]    job_sums [osam_pkg::MAX_OPS],
  output logic                pop,
  osam_res_if.source          res
);
  import osam_pkg::*;

  // quotient never exceeds OPERAND_WIDTH * 2^F
  localparam int QW   = $clog2(OPERAND_WIDTH + 1) + FRACTION_BITS;
  localparam int DW   = SUM_W + FRACTION_BITS;
  localparam int STW  = $clog2(QW);

  back_state_t state, state_next;

  job_ctl_t         ctl;
  logic [SC_W-1:0]  divisor;
  logic [SC_W-1:0]  rem [MAX_OPS];
  logic [QW-1:0]    qsh [MAX_OPS];
  logic [STW-1:0]   step;
  logic             load_out;
  logic             out_valid;
  logic [DW-1:0]    dvd [MAX_OPS];
  logic [SC_W:0]    trial [MAX_OPS];
  logic [AVG_W-1:0] avg [MAX_OPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (step == '0) state_next = B_HOLD;
      end
      B_HOLD: begin
        if (!out_valid || res.ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    for (int k = 0; k < MAX_OPS; k++) begin
      dvd[k]   = {job_sums[k], FRACTION_BITS'(0)};
      trial[k] = {rem[k], qsh[k][QW-1]};
      avg[k]   = (CNT_W'(k) < ctl.operand_count && ctl.sample_count >= SC_W'(2))
               ? AVG_W'(qsh[k]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ctl     <= job_ctl;
      divisor <= job_ctl.sample_count - SC_W'(1);
      step    <= STW'(QW - 1);
      for (int k = 0; k < MAX_OPS; k++) begin
        rem[k] <= dvd[k][DW-1:QW];
        qsh[k] <= dvd[k][QW-1:0];
      end
    end else if (state == B_DIV) begin
      step <= step - STW'(1);
      for (int k = 0; k < MAX_OPS; k++) begin
        if (trial[k] >= {1'b0, divisor}) begin
          rem[k] <= SC_W'(trial[k] - {1'b0, divisor});
          qsh[k] <= {qsh[k][QW-2:0], 1'b1};
        end else begin
          rem[k] <= trial[k][SC_W-1:0];
          qsh[k] <= {qsh[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.status             <= ctl.status;
      res.sample_count       <= ctl.sample_count;
      res.average_distance_a <= avg[0];
      res.average_distance_b <= avg[1];
      res.average_distance_c <= avg[2];
    end
  end

  assign res.valid = out_valid;

endmodule

`default_nettype wire

[src/operand_switching_activity_monitor_top.sv]
// ----------------------------------------------------------------------------
// operand_switching_activity_monitor_top: operand toggle-rate monitor
// Per-operator Hamming distance sums with fixed-point average reporting.
//
//   channel  dir  handshake      payload
//   evt      in   valid/ready    operator_id, operand_count, operand_a/b/c
//   res      out  valid/ready    status, sample_count, average_distance_a/b/c
//
// The front reads an event's table entry, then writes it back and queues it,
// taking no new event until then. The idle back pops an item and computes QW
// quotient bits with bit-per-cycle restoring dividers, where QW =
// clog2(OPERAND_WIDTH+1) + FRACTION_BITS (22 at defaults), then loads the
// result register. Reset clears all entry valid bits; no clearing pass.
// A two-entry queue and the result register let either side stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module operand_switching_activity_monitor_top #(
  parameter int OPERATOR_SLOTS = 256,
  parameter int OPERAND_WIDTH  = 32,
  parameter int FRACTION_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  osam_evt_if.sink   evt,
  osam_res_if.source res
);
  import osam_pkg::*;

  localparam int SUM_W = SC_W + $clog2(OPERAND_WIDTH + 1);
  localparam int CTL_W = $bits(job_ctl_t);
  localparam int QD_W  = CTL_W + MAX_OPS * SUM_W;

  logic             push, pop, full, empty;
  job_ctl_t         push_ctl, pop_ctl;
  logic [SUM_W-1:0] push_sums [MAX_OPS];
  logic [SUM_W-1:0] pop_sums  [MAX_OPS];
  logic [QD_W-1:0]  q_wdata, q_rdata;

  osam_front #(
    .OPERATOR_SLOTS (OPERATOR_SLOTS),
    .OPERAND_WIDTH  (OPERAND_WIDTH),
    .SUM_W          (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_sums (push_sums),
    .full      (full)
  );

  assign q_wdata = {push_ctl, push_sums[2], push_sums[1], push_sums[0]};

  osam_fifo #(
    .W (QD_W)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (empty)
  );

  assign pop_ctl     = q_rdata[QD_W-1:MAX_OPS*SUM_W];
  assign pop_sums[2] = q_rdata[3*SUM_W-1:2*SUM_W];
  assign pop_sums[1] = q_rdata[2*SUM_W-1:SUM_W];
  assign pop_sums[0] = q_rdata[SUM_W-1:0];

  osam_back #(
    .OPERAND_WIDTH (OPERAND_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .SUM_W         (SUM_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .job_ctl  (pop_ctl),
    .job_sums (pop_sums),
    .pop      (pop),
    .res      (res)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");

  a_created: assert property (@(posedge clk) disable iff (rst)
      res.valid && res.status == ST_CREATED |->
      res.sample_count == SC_W'(1) && res.average_distance_a == '0 &&
      res.average_distance_b == '0 && res.average_distance_c == '0)
    else $error("new entry reported with nonzero state");

  a_updated: assert property (@(posedge clk) disable iff (rst)
      res.valid && res.status == ST_UPDATED |-> res.sample_count >= SC_W'(2))
    else $error("update reported with fewer than two samples");

  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !res.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
